[rtl/core/thrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thrs_pkg : shared types and codes for the tip height raster scan
// Item, result and register-set structs, command, action and register codes.
// ----------------------------------------------------------------------------
package thrs_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned SIDE_W = 9;
  localparam int unsigned COL_W  = 8;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } thrs_cmd_t;

  typedef enum logic [1:0] {
    ACT_MEASURE = 2'd0,
    ACT_MOVE    = 2'd1,
    ACT_RECORD  = 2'd2,
    ACT_IDLE    = 2'd3
  } thrs_action_t;

  typedef enum logic [1:0] {
    REG_SIDE_LEN   = 2'd0,
    REG_MAX_STEPS  = 2'd1,
    REG_ADJ_DELTA  = 2'd2,
    REG_TARGET_SIG = 2'd3
  } thrs_reg_t;

  localparam logic [SIDE_W-1:0] SIDE_LEN_RST   = 9'd64;
  localparam logic [POS_W-1:0]  MAX_STEPS_RST  = 16'd16;
  localparam logic [POS_W-1:0]  ADJ_DELTA_RST  = 16'd1;
  localparam logic [POS_W-1:0]  TARGET_SIG_RST = 16'd32768;
  localparam logic [SIDE_W-1:0] SIDE_MAX       = 9'd256;

  typedef struct packed {
    logic [SIDE_W-1:0] side_len;
    logic [POS_W-1:0]  max_adjust_steps;
    logic [POS_W-1:0]  adjust_delta;
    logic [POS_W-1:0]  target_signal;
  } thrs_cfg_t;

  typedef struct packed {
    thrs_cmd_t        command;
    logic [POS_W-1:0] start_position;
    logic [POS_W-1:0] sample;
  } thrs_item_t;

  typedef struct packed {
    thrs_action_t     action;
    logic [COL_W-1:0] pos_x;
    logic [COL_W-1:0] pos_y;
    logic [POS_W-1:0] height;
    logic [POS_W-1:0] signal_out;
    logic             scan_done;
  } thrs_result_t;

endpackage

`default_nettype wire

[rtl/core/thrs_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thrs_cfg_regs : APB register set
// Four scan registers at word addresses, always ready, read back zero-extended.
// ----------------------------------------------------------------------------
module thrs_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [thrs_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [thrs_pkg::DATA_W-1:0]   pwdata,
  output logic      [thrs_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output thrs_pkg::thrs_cfg_t                cfg
);

  thrs_pkg::thrs_cfg_t cfg_r;
  thrs_pkg::thrs_cfg_t cfg_nxt;
  thrs_pkg::thrs_reg_t reg_sel;
  logic                wr_en;

  assign reg_sel = thrs_pkg::thrs_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        thrs_pkg::REG_SIDE_LEN:   cfg_nxt.side_len         = pwdata[thrs_pkg::SIDE_W-1:0];
        thrs_pkg::REG_MAX_STEPS:  cfg_nxt.max_adjust_steps = pwdata[thrs_pkg::POS_W-1:0];
        thrs_pkg::REG_ADJ_DELTA:  cfg_nxt.adjust_delta     = pwdata[thrs_pkg::POS_W-1:0];
        thrs_pkg::REG_TARGET_SIG: cfg_nxt.target_signal    = pwdata[thrs_pkg::POS_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      thrs_pkg::REG_SIDE_LEN:   prdata = {23'd0, cfg_r.side_len};
      thrs_pkg::REG_MAX_STEPS:  prdata = {16'd0, cfg_r.max_adjust_steps};
      thrs_pkg::REG_ADJ_DELTA:  prdata = {16'd0, cfg_r.adjust_delta};
      thrs_pkg::REG_TARGET_SIG: prdata = {16'd0, cfg_r.target_signal};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.side_len         <= thrs_pkg::SIDE_LEN_RST;
      cfg_r.max_adjust_steps <= thrs_pkg::MAX_STEPS_RST;
      cfg_r.adjust_delta     <= thrs_pkg::ADJ_DELTA_RST;
      cfg_r.target_signal    <= thrs_pkg::TARGET_SIG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/thrs_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thrs_step : feedback stepper and raster counters
// Holds tip height, pixel counters and loop flags; works out one result per
// item and commits the new state on step_en.
// ----------------------------------------------------------------------------
module thrs_step (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  thrs_pkg::thrs_item_t      item,
  input  thrs_pkg::thrs_cfg_t       cfg,
  output thrs_pkg::thrs_result_t    result
);

  logic [thrs_pkg::POS_W-1:0]  disp_r,      disp_nxt;
  logic [thrs_pkg::COL_W-1:0]  col_r,       col_nxt;
  logic [thrs_pkg::SIDE_W-1:0] row_r,       row_nxt;
  logic [thrs_pkg::POS_W-1:0]  move_cnt_r,  move_cnt_nxt;
  logic                        moving_up_r, moving_up_nxt;
  logic                        adjusting_r, adjusting_nxt;
  logic                        finished_r,  finished_nxt;

  logic [thrs_pkg::SIDE_W-1:0] eff_side;
  logic                        up_sel;
  logic                        reached;
  logic                        do_record;
  logic [thrs_pkg::POS_W:0]    sum_down;
  logic [thrs_pkg::POS_W-1:0]  disp_moved;
  logic                        col_last;
  logic                        row_last;

  always_comb begin
    if (cfg.side_len == '0) begin
      eff_side = thrs_pkg::SIDE_W'(1);
    end else if (cfg.side_len > thrs_pkg::SIDE_MAX) begin
      eff_side = thrs_pkg::SIDE_MAX;
    end else begin
      eff_side = cfg.side_len;
    end
  end

  // direction is picked on the first sample of a pixel, then held
  assign up_sel  = adjusting_r ? moving_up_r : (item.sample > cfg.target_signal);
  assign reached = moving_up_r ? (item.sample < cfg.target_signal)
                               : (item.sample > cfg.target_signal);

  always_comb begin
    if (!adjusting_r) begin
      do_record = (cfg.max_adjust_steps == '0);
    end else begin
      do_record = reached || (move_cnt_r >= cfg.max_adjust_steps);
    end
  end

  // saturating move
  assign sum_down = {1'b0, disp_r} + {1'b0, cfg.adjust_delta};
  always_comb begin
    if (up_sel) begin
      disp_moved = (disp_r > cfg.adjust_delta) ? (disp_r - cfg.adjust_delta) : '0;
    end else begin
      disp_moved = sum_down[thrs_pkg::POS_W] ? '1 : sum_down[thrs_pkg::POS_W-1:0];
    end
  end

  assign col_last = ({1'b0, col_r} + thrs_pkg::SIDE_W'(1)) >= eff_side;
  assign row_last = ({1'b0, row_r} + (thrs_pkg::SIDE_W+1)'(1)) >= {1'b0, eff_side};

  always_comb begin
    disp_nxt      = disp_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    move_cnt_nxt  = move_cnt_r;
    moving_up_nxt = moving_up_r;
    adjusting_nxt = adjusting_r;
    finished_nxt  = finished_r;

    result.action     = thrs_pkg::ACT_IDLE;
    result.pos_x      = '0;
    result.pos_y      = '0;
    result.height     = disp_r;
    result.signal_out = '0;
    result.scan_done  = 1'b1;

    if (item.command == thrs_pkg::CMD_START) begin
      disp_nxt      = item.start_position;
      col_nxt       = '0;
      row_nxt       = '0;
      move_cnt_nxt  = '0;
      moving_up_nxt = 1'b0;
      adjusting_nxt = 1'b0;
      finished_nxt  = 1'b0;
      result.action    = thrs_pkg::ACT_MEASURE;
      result.height    = item.start_position;
      result.scan_done = 1'b0;
    end else if (!finished_r) begin
      moving_up_nxt     = up_sel;
      result.pos_x      = col_r;
      result.pos_y      = row_r[thrs_pkg::COL_W-1:0];
      result.signal_out = item.sample;
      if (!do_record) begin
        disp_nxt      = disp_moved;
        move_cnt_nxt  = adjusting_r ? (move_cnt_r + thrs_pkg::POS_W'(1))
                                    : thrs_pkg::POS_W'(1);
        adjusting_nxt = 1'b1;
        result.action    = thrs_pkg::ACT_MOVE;
        result.height    = disp_moved;
        result.scan_done = 1'b0;
      end else begin
        adjusting_nxt = 1'b0;
        move_cnt_nxt  = '0;
        if (col_last) begin
          col_nxt = '0;
          if (row_last) begin
            finished_nxt = 1'b1;
            row_nxt      = eff_side;
          end else begin
            row_nxt = row_r + thrs_pkg::SIDE_W'(1);
          end
        end else begin
          col_nxt = col_r + thrs_pkg::COL_W'(1);
        end
        result.action    = thrs_pkg::ACT_RECORD;
        result.scan_done = col_last && row_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      move_cnt_r  <= '0;
      moving_up_r <= 1'b0;
      adjusting_r <= 1'b0;
      finished_r  <= 1'b1;
    end else if (step_en) begin
      disp_r      <= disp_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      move_cnt_r  <= move_cnt_nxt;
      moving_up_r <= moving_up_nxt;
      adjusting_r <= adjusting_nxt;
      finished_r  <= finished_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tip_height_raster_scan_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tip_height_raster_scan_top : constant-current raster scan stepper
// Input register, combinational feedback step, result register, APB registers.
// ----------------------------------------------------------------------------
//  port group  | handshake          | beat contents
//  ------------+--------------------+-------------------------------------------
//  in_*        | in_valid/in_stall  | command, start_position, sample
//  out_*       | out_valid/out_stall| action, pos_x, pos_y, height, signal_out,
//              |                    | scan_done
//  APB         | psel/penable/pready| four scan registers at byte address 4*i
//
//  One beat in and one beat out per cycle sustained while out_stall is low;
//  a beat passes input register, single step stage, result register.
//  Reset (rst_n low, synchronous) empties both registers and leaves the scan
//  finished, so samples give idle results until a start beat arrives.
//  out_stall holds the result register; in_stall rises only when a beat is
//  waiting in the input register and the result register cannot drain.
// ----------------------------------------------------------------------------
module tip_height_raster_scan_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_command,
  input  wire logic [thrs_pkg::POS_W-1:0]         in_start_position,
  input  wire logic [thrs_pkg::POS_W-1:0]         in_sample,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [1:0]                         out_action,
  output logic      [thrs_pkg::COL_W-1:0]         out_pos_x,
  output logic      [thrs_pkg::COL_W-1:0]         out_pos_y,
  output logic      [thrs_pkg::POS_W-1:0]         out_height,
  output logic      [thrs_pkg::POS_W-1:0]         out_signal_out,
  output logic                                    out_scan_done,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [thrs_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [thrs_pkg::DATA_W-1:0]        pwdata,
  output logic      [thrs_pkg::DATA_W-1:0]        prdata,
  output logic                                    pready
);

  thrs_pkg::thrs_cfg_t    cfg;
  thrs_pkg::thrs_item_t   item_r;
  thrs_pkg::thrs_result_t result;
  thrs_pkg::thrs_result_t res_r;
  logic                   item_valid_r, item_valid_nxt;
  logic                   res_valid_r,  res_valid_nxt;
  logic                   advance;
  logic                   in_take;

  thrs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  thrs_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // step the held beat whenever the result register is free or draining
  assign advance  = item_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_take) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (advance) begin
      res_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.command        <= thrs_pkg::thrs_cmd_t'(in_command);
      item_r.start_position <= in_start_position;
      item_r.sample         <= in_sample;
    end
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_valid      = res_valid_r;
  assign out_action     = res_r.action;
  assign out_pos_x      = res_r.pos_x;
  assign out_pos_y      = res_r.pos_y;
  assign out_height     = res_r.height;
  assign out_signal_out = res_r.signal_out;
  assign out_scan_done  = res_r.scan_done;

endmodule

`default_nettype wire

[rtl/core/thrs_port_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thrs_port_checker : port-level checks for the raster scan top
// Watches result beats for consistency of action codes and reset behaviour.
// ----------------------------------------------------------------------------
module thrs_port_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [1:0]                  out_action,
  input wire logic [thrs_pkg::COL_W-1:0]  out_pos_x,
  input wire logic [thrs_pkg::COL_W-1:0]  out_pos_y,
  input wire logic [thrs_pkg::POS_W-1:0]  out_height,
  input wire logic [thrs_pkg::POS_W-1:0]  out_signal_out,
  input wire logic                        out_scan_done
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action)
      && $stable(out_height) && $stable(out_pos_x) && $stable(out_pos_y))
    else $error("stalled result beat changed");

  a_idle_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == thrs_pkg::ACT_IDLE |->
      out_pos_x == '0 && out_pos_y == '0 && out_signal_out == '0 && out_scan_done)
    else $error("idle beat with pixel data");

  a_start_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == thrs_pkg::ACT_MEASURE |->
      out_pos_x == '0 && out_pos_y == '0 && out_signal_out == '0 && !out_scan_done)
    else $error("start beat not at first pixel");

  a_move_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == thrs_pkg::ACT_MOVE |-> !out_scan_done)
    else $error("move beat flagged as scan done");

endmodule

bind tip_height_raster_scan_top thrs_port_checker u_port_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_action     (out_action),
  .out_pos_x      (out_pos_x),
  .out_pos_y      (out_pos_y),
  .out_height     (out_height),
  .out_signal_out (out_signal_out),
  .out_scan_done  (out_scan_done)
);

`default_nettype wire

[dv/tip_height_raster_scan_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tip_height_raster_scan_checker : scoreboard for the raster scan stepper
// Follows register writes, predicts one result beat per accepted input beat
// and compares every accepted result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tip_height_raster_scan_checker
  import thrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_command,
  input  logic [POS_W-1:0]    in_start_position,
  input  logic [POS_W-1:0]    in_sample,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [1:0]          out_action,
  input  logic [COL_W-1:0]    out_pos_x,
  input  logic [COL_W-1:0]    out_pos_y,
  input  logic [POS_W-1:0]    out_height,
  input  logic [POS_W-1:0]    out_signal_out,
  input  logic                out_scan_done,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output int                  due_count,
  output int                  fails
);

  thrs_cfg_t         regs;
  logic [POS_W-1:0]  tip_z;
  logic [COL_W-1:0]  col;
  logic [SIDE_W-1:0] row;
  logic [POS_W-1:0]  moves;
  logic              going_up;
  logic              seeking;
  logic              scan_over;

  thrs_result_t results_due[$];

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
    fails++;
  endtask

  // one piezo move towards the target, clamped to the displacement range
  function automatic void nudge();
    int unsigned sum;
    if (going_up) begin
      tip_z = (tip_z > regs.adjust_delta) ? tip_z - regs.adjust_delta : '0;
    end else begin
      sum   = 32'(tip_z) + 32'(regs.adjust_delta);
      tip_z = (sum > 16'hFFFF) ? 16'hFFFF : sum[POS_W-1:0];
    end
    moves = moves + 1'b1;
  endfunction

  function automatic thrs_result_t scan_step(input thrs_item_t beat);
    thrs_result_t r;
    int unsigned  side;
    logic         record;
    r      = '0;
    record = 1'b0;
    side   = (regs.side_len == 0) ? 1 :
             (regs.side_len > SIDE_MAX) ? SIDE_MAX : regs.side_len;

    if (beat.command == CMD_START) begin
      tip_z     = beat.start_position;
      col       = '0;
      row       = '0;
      moves     = '0;
      going_up  = 1'b0;
      seeking   = 1'b0;
      scan_over = 1'b0;
      r.action  = ACT_MEASURE;
      r.height  = tip_z;
      return r;
    end

    if (scan_over) begin
      r.action    = ACT_IDLE;
      r.height    = tip_z;
      r.scan_done = 1'b1;
      return r;
    end

    if (!seeking) begin
      // first sample at a pixel picks the direction
      going_up = beat.sample > regs.target_signal;
      moves    = '0;
      if (regs.max_adjust_steps == 0) begin
        record = 1'b1;
      end else begin
        nudge();
        seeking = 1'b1;
      end
    end else if ((going_up ? beat.sample < regs.target_signal
                           : beat.sample > regs.target_signal) ||
                 moves >= regs.max_adjust_steps) begin
      record = 1'b1;
    end else begin
      nudge();
    end

    r.pos_x      = col;
    r.pos_y      = row[COL_W-1:0];
    r.height     = tip_z;
    r.signal_out = beat.sample;
    if (!record) begin
      r.action = ACT_MOVE;
      return r;
    end

    r.action = ACT_RECORD;
    seeking  = 1'b0;
    moves    = '0;
    if (col + 1 >= side) begin
      col = '0;
      if (row + 1 >= side) begin
        scan_over = 1'b1;
        row       = side[SIDE_W-1:0];
      end else begin
        row = row + 1'b1;
      end
    end else begin
      col = col + 1'b1;
    end
    r.scan_done = scan_over;
    return r;
  endfunction

  always @(posedge clk) begin
    thrs_result_t want;
    if (!rst_n) begin
      regs      <= '{SIDE_LEN_RST, MAX_STEPS_RST, ADJ_DELTA_RST, TARGET_SIG_RST};
      tip_z     = '0;
      col       = '0;
      row       = '0;
      moves     = '0;
      going_up  = 1'b0;
      seeking   = 1'b0;
      scan_over = 1'b1;
      results_due.delete();
      due_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (thrs_reg_t'(paddr[3:2]))
          REG_SIDE_LEN:   regs.side_len         <= pwdata[SIDE_W-1:0];
          REG_MAX_STEPS:  regs.max_adjust_steps <= pwdata[POS_W-1:0];
          REG_ADJ_DELTA:  regs.adjust_delta     <= pwdata[POS_W-1:0];
          REG_TARGET_SIG: regs.target_signal    <= pwdata[POS_W-1:0];
          default: ;
        endcase
      end

      // drain before fill so an early beat is never matched to its own prediction
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          flag("result beat with nothing due, action", out_action, '0);
        end else begin
          want = results_due.pop_front();
          if (out_action !== want.action)         flag("action", out_action, want.action);
          if (out_pos_x !== want.pos_x)           flag("pos_x", out_pos_x, want.pos_x);
          if (out_pos_y !== want.pos_y)           flag("pos_y", out_pos_y, want.pos_y);
          if (out_height !== want.height)         flag("height", out_height, want.height);
          if (out_signal_out !== want.signal_out) flag("signal_out", out_signal_out,
                                                       want.signal_out);
          if (out_scan_done !== want.scan_done)   flag("scan_done", out_scan_done,
                                                       want.scan_done);
        end
      end

      if (in_valid && !in_stall)
        results_due.push_back(scan_step(thrs_item_t'{thrs_cmd_t'(in_command),
                                                     in_start_position, in_sample}));

      due_count <= results_due.size();
    end
  end

endmodule

[dv/tip_height_raster_scan_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tip_height_raster_scan_top_tb : stimulus and verdict for the scan stepper
// Directed beats for clamping, step limits, restarts and side-length edges,
// then random scan phases with new register settings, random gaps on both
// channels, one long result hold-off and one stretch without gaps.
// ----------------------------------------------------------------------------
module tip_height_raster_scan_top_tb;
  import thrs_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_command = 1'b0;
  logic [POS_W-1:0]    in_start_position = '0;
  logic [POS_W-1:0]    in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_action;
  logic [COL_W-1:0]    out_pos_x;
  logic [COL_W-1:0]    out_pos_y;
  logic [POS_W-1:0]    out_height;
  logic [POS_W-1:0]    out_signal_out;
  logic                out_scan_done;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int   due_count;
  int   fails;
  int   cycle_count = 0;
  logic no_gaps = 1'b0;
  logic hold_request = 1'b0;

  always #5 clk = ~clk;

  tip_height_raster_scan_top dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_start_position, .in_sample,
    .out_valid, .out_stall, .out_action, .out_pos_x, .out_pos_y,
    .out_height, .out_signal_out, .out_scan_done,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tip_height_raster_scan_checker scoreboard (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_start_position, .in_sample,
    .out_valid, .out_stall, .out_action, .out_pos_x, .out_pos_y,
    .out_height, .out_signal_out, .out_scan_done,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .due_count, .fails
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= rst_n && !no_gaps && ($urandom_range(99) < 23);
    end
  end

  function automatic logic [POS_W-1:0] rand_word();
    logic [31:0] v;
    v = $urandom;
    return v[POS_W-1:0];
  endfunction

  task automatic send_beat(input thrs_cmd_t cmd, input logic [POS_W-1:0] pos,
                           input logic [POS_W-1:0] smp);
    // idle cycle by cycle at random before offering the beat
    while (!no_gaps && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_start_position <= pos;
    in_sample         <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every predicted beat to come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input thrs_reg_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int               sent;
    int               phase;
    int               len;
    int               r;
    logic [POS_W-1:0] tgt;
    logic [POS_W-1:0] smp;
    sent  = 0;
    phase = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // the scan comes out of reset finished, so a sample gets an idle beat
    send_beat(CMD_SAMPLE, rand_word(), 16'h1234);
    drain();
    reg_write(REG_SIDE_LEN, 2);
    reg_write(REG_MAX_STEPS, 3);
    reg_write(REG_ADJ_DELTA, 32'hFFFF);
    reg_write(REG_TARGET_SIG, 32'h8000);
    send_beat(CMD_START, 16'h0000, rand_word());
    send_beat(CMD_SAMPLE, rand_word(), 16'hFFFF);   // up from zero, clamp low
    send_beat(CMD_SAMPLE, rand_word(), 16'h8000);   // level with target: keep going
    send_beat(CMD_SAMPLE, rand_word(), 16'h0000);   // crossed: record
    send_beat(CMD_SAMPLE, rand_word(), 16'h0000);   // down
    send_beat(CMD_SAMPLE, rand_word(), 16'h8000);   // clamp high
    send_beat(CMD_SAMPLE, rand_word(), 16'h7FFF);
    send_beat(CMD_SAMPLE, rand_word(), 16'h7FFF);   // step limit reached
    send_beat(CMD_SAMPLE, rand_word(), 16'hFFFF);   // up by exactly the height
    send_beat(CMD_SAMPLE, rand_word(), 16'h0000);
    send_beat(CMD_SAMPLE, rand_word(), 16'h0000);
    send_beat(CMD_SAMPLE, rand_word(), 16'hFFFF);   // last pixel
    send_beat(CMD_SAMPLE, rand_word(), rand_word()); // ignored once done
    send_beat(CMD_START, 16'h5A5A, rand_word());
    send_beat(CMD_SAMPLE, rand_word(), 16'h0001);
    send_beat(CMD_START, 16'hA5A5, rand_word());    // restart mid pixel
    drain();
    reg_write(REG_SIDE_LEN, 0);                  // acts as one
    reg_write(REG_MAX_STEPS, 0);                 // record without moving
    send_beat(CMD_SAMPLE, rand_word(), 16'h4000);
    send_beat(CMD_SAMPLE, rand_word(), 16'h4000);
    drain();
    reg_write(REG_SIDE_LEN, 4);
    reg_write(REG_MAX_STEPS, 1);
    reg_write(REG_ADJ_DELTA, 32'h0100);
    reg_write(REG_TARGET_SIG, 32'h0000);
    send_beat(CMD_START, 16'h1000, rand_word());
    send_beat(CMD_SAMPLE, rand_word(), 16'h0000);
    send_beat(CMD_SAMPLE, rand_word(), 16'h0000);
    drain();
    reg_write(REG_SIDE_LEN, 1);                  // shrink under a running scan
    send_beat(CMD_SAMPLE, rand_word(), 16'h0000);
    send_beat(CMD_SAMPLE, rand_word(), 16'h0000);

    while (sent < RANDOM_ITEMS) begin
      drain();
      r = $urandom_range(15);
      if (r < 10)       reg_write(REG_SIDE_LEN, $urandom_range(4, 1));
      else if (r < 12)  reg_write(REG_SIDE_LEN, $urandom_range(12, 5));
      else if (r == 12) reg_write(REG_SIDE_LEN, 32'(SIDE_MAX));
      else if (r == 13) reg_write(REG_SIDE_LEN, 0);
      else if (r == 14) reg_write(REG_SIDE_LEN, $urandom_range(511, 257));
      else              reg_write(REG_SIDE_LEN, 1);
      r = $urandom_range(15);
      if (r < 8)        reg_write(REG_MAX_STEPS, $urandom_range(5, 1));
      else if (r == 8)  reg_write(REG_MAX_STEPS, 0);
      else if (r == 9)  reg_write(REG_MAX_STEPS, 32'hFFFF);
      else              reg_write(REG_MAX_STEPS, $urandom_range(3, 1));
      r = $urandom_range(4);
      case (r)
        0:       reg_write(REG_ADJ_DELTA, 0);
        1:       reg_write(REG_ADJ_DELTA, 1);
        2:       reg_write(REG_ADJ_DELTA, 32'hFFFF);
        3:       reg_write(REG_ADJ_DELTA, $urandom_range(16'hFFFF, 0));
        default: reg_write(REG_ADJ_DELTA, $urandom_range(16'h1000, 0));
      endcase
      r = $urandom_range(3);
      case (r)
        0:       tgt = 16'h0000;
        1:       tgt = 16'hFFFF;
        2:       tgt = rand_word();
        default: tgt = POS_W'($urandom_range(16'h9000, 16'h7000));
      endcase
      reg_write(REG_TARGET_SIG, 32'(tgt));

      no_gaps = (phase == 2);
      if (phase == 4) hold_request = 1'b1;
      len = $urandom_range(55, 25);
      send_beat(CMD_START, rand_word(), rand_word());
      for (int k = 1; k < len; k++) begin
        r = $urandom_range(99);
        if (r < 6) begin
          send_beat(CMD_START, rand_word(), rand_word());
        end else begin
          // mostly either side of the target so pixels settle or run out of steps
          if (r < 45 && tgt > 0)
            smp = POS_W'($urandom_range(tgt - 1, 0));
          else if (r < 84 && tgt < 16'hFFFF)
            smp = POS_W'($urandom_range(16'hFFFF, tgt + 1));
          else if (r < 90)
            smp = tgt;
          else
            smp = rand_word();
          send_beat(CMD_SAMPLE, rand_word(), smp);
        end
      end
      no_gaps = 1'b0;
      sent += len;
      phase++;
    end

    drain();
    if (fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
